// File: rtl/core/agls_pkg.sv
// shared constants and item types for the asap gate layer scheduler
package agls_pkg;

    localparam int NUM_QUBITS = 256;
    localparam int QUBIT_BITS = $clog2(NUM_QUBITS);
    localparam int LAYER_BITS = 16;
    localparam int DEPTH_BITS = LAYER_BITS + 1;
    localparam int COUNT_BITS = 2;
    localparam int LANES      = 3;

    localparam logic [LAYER_BITS-1:0] LAYER_TOP = {LAYER_BITS{1'b1}};

    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_CLEAR    = 1'b1;

    typedef struct packed {
        logic                  command;
        logic [COUNT_BITS-1:0] qubit_count;
        logic [QUBIT_BITS-1:0] qubit_a;
        logic [QUBIT_BITS-1:0] qubit_b;
        logic [QUBIT_BITS-1:0] qubit_c;
    } agls_in_t;

    typedef struct packed {
        logic [LAYER_BITS-1:0] layer_index;
        logic [DEPTH_BITS-1:0] circuit_depth;
        logic                  layer_saturated;
    } agls_out_t;

    // table write, one port per lane
    typedef struct packed {
        logic [LANES-1:0]                 en;
        logic [LANES-1:0][QUBIT_BITS-1:0] addr;
        logic [LAYER_BITS-1:0]            layer;
    } agls_write_t;

    // what one lane found for its qubit
    typedef struct packed {
        logic                  seen;
        logic [LAYER_BITS-1:0] last;
    } agls_lane_t;

endpackage

// File: rtl/core/agls_lane.sv
// one lookup lane: a bank per write port, registered read, forwarding of the write at read time
module agls_lane import agls_pkg::*; (
    input  logic                             clk,
    input  logic                             rd_en,
    input  logic [QUBIT_BITS-1:0]            rd_addr,
    input  agls_write_t                      wr,
    input  logic [LANES-1:0][NUM_QUBITS-1:0] bank_valid,
    output agls_lane_t                       found
);

    logic [QUBIT_BITS-1:0]            addr_reg;
    logic                             hit_reg;
    logic                             hit_next;
    logic [LAYER_BITS-1:0]            fwd_reg;
    logic [LANES-1:0][LAYER_BITS-1:0] rd_data;

    // write landing on the same edge as the read is missed by the bank
    always_comb
    begin
        hit_next = 1'b0;
        for (int k = 0; k < LANES; k++)
        begin
            if (wr.en[k] && (wr.addr[k] == rd_addr))
            begin
                hit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            addr_reg <= rd_addr;
            hit_reg  <= hit_next;
            fwd_reg  <= wr.layer;
        end
    end

    for (genvar b = 0; b < LANES; b++)
    begin : g_bank
        logic [LAYER_BITS-1:0] bank_reg [NUM_QUBITS];
        logic [LAYER_BITS-1:0] rdata_reg;

        always_ff @(posedge clk)
        begin
            if (wr.en[b])
            begin
                bank_reg[wr.addr[b]] <= wr.layer;
            end
            if (rd_en)
            begin
                rdata_reg <= bank_reg[rd_addr];
            end
        end

        assign rd_data[b] = rdata_reg;
    end

    // layers only grow within a circuit, so the largest valid copy is the latest
    always_comb
    begin
        logic                  any;
        logic [LAYER_BITS-1:0] best;
        any  = 1'b0;
        best = '0;
        for (int b = 0; b < LANES; b++)
        begin
            if (bank_valid[b][addr_reg])
            begin
                any = 1'b1;
                if (rd_data[b] > best)
                begin
                    best = rd_data[b];
                end
            end
        end
        if (hit_reg)
        begin
            found.seen = 1'b1;
            found.last = fwd_reg;
        end
        else
        begin
            found.seen = any;
            found.last = best;
        end
    end

endmodule

// File: rtl/core/agls_merge.sv
// merges lane findings into the gate layer, saturation flag and new depth; a clear gives all zero
module agls_merge import agls_pkg::*; (
    input  agls_lane_t [LANES-1:0] found,
    input  logic                   command,
    input  logic [COUNT_BITS-1:0]  qubit_count,
    input  logic [DEPTH_BITS-1:0]  depth,
    output agls_out_t              result
);

    always_comb
    begin
        logic [LAYER_BITS-1:0] layer;
        logic [LAYER_BITS-1:0] cand;
        logic                  sat;
        logic [DEPTH_BITS-1:0] layer_plus;
        layer = '0;
        cand  = '0;
        sat   = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            if ((COUNT_BITS'(i) < qubit_count) && found[i].seen)
            begin
                if (found[i].last == LAYER_TOP)
                begin
                    cand = LAYER_TOP;
                    sat  = 1'b1;
                end
                else
                begin
                    cand = found[i].last + 1'b1;
                end
                if (cand > layer)
                begin
                    layer = cand;
                end
            end
        end
        layer_plus = {1'b0, layer} + 1'b1;

        if (command == CMD_CLEAR)
        begin
            result = '0;
        end
        else
        begin
            result.layer_index     = layer;
            result.circuit_depth   = (depth > layer_plus) ? depth : layer_plus;
            result.layer_saturated = sat;
        end
    end

endmodule

// File: rtl/core/asap_gate_layer_scheduler.sv
// top level of the asap gate layer scheduler
// Takes one item per clock while the result side does not stall; its result comes
// from a table read, then merge and write-back into the output register. A stall on
// the result side holds the merge stage and then the input. Each of the three
// qubit lanes reads its own copy of the last-layer table, kept as one 256-entry
// bank per write port, and a write that lands on the same edge as a read is
// forwarded. Seen marks are flip-flops, so a clear command takes effect at once
// and no clearing pass runs after reset.
module asap_gate_layer_scheduler import agls_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      gate_valid,
    output logic      gate_stall,
    input  agls_in_t  gate_item,
    output logic      result_valid,
    input  logic      result_stall,
    output agls_out_t result_item
);

    logic                             accept;
    logic                             advance;
    logic                             s1_valid_reg;
    logic                             s1_valid_next;
    agls_in_t                         s1_item_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    agls_out_t                        out_item_reg;
    logic [DEPTH_BITS-1:0]            depth_reg;
    logic [LANES-1:0][NUM_QUBITS-1:0] bank_valid_reg;
    logic [LANES-1:0][NUM_QUBITS-1:0] bank_valid_next;
    logic [LANES-1:0][QUBIT_BITS-1:0] rd_addr;
    logic [LANES-1:0][QUBIT_BITS-1:0] s1_addr;
    agls_lane_t [LANES-1:0]           found;
    agls_out_t                        merged;
    agls_write_t                      wr;

    assign accept     = gate_valid & ~gate_stall;
    assign advance    = s1_valid_reg & (~out_valid_reg | ~result_stall);
    assign gate_stall = s1_valid_reg & ~advance;

    assign rd_addr[0] = gate_item.qubit_a;
    assign rd_addr[1] = gate_item.qubit_b;
    assign rd_addr[2] = gate_item.qubit_c;
    assign s1_addr[0] = s1_item_reg.qubit_a;
    assign s1_addr[1] = s1_item_reg.qubit_b;
    assign s1_addr[2] = s1_item_reg.qubit_c;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        agls_lane u_lane (
            .clk        (clk),
            .rd_en      (accept),
            .rd_addr    (rd_addr[i]),
            .wr         (wr),
            .bank_valid (bank_valid_reg),
            .found      (found[i])
        );
    end

    agls_merge u_merge (
        .found       (found),
        .command     (s1_item_reg.command),
        .qubit_count (s1_item_reg.qubit_count),
        .depth       (depth_reg),
        .result      (merged)
    );

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            wr.en[i] = advance && (s1_item_reg.command == CMD_SCHEDULE)
                       && (COUNT_BITS'(i) < s1_item_reg.qubit_count);
        end
        wr.addr  = s1_addr;
        wr.layer = merged.layer_index;
    end

    always_comb
    begin
        bank_valid_next = bank_valid_reg;
        if (advance && (s1_item_reg.command == CMD_CLEAR))
        begin
            bank_valid_next = '0;
        end
        else
        begin
            for (int b = 0; b < LANES; b++)
            begin
                if (wr.en[b])
                begin
                    bank_valid_next[b][wr.addr[b]] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            depth_reg      <= '0;
            bank_valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            bank_valid_reg <= bank_valid_next;
            if (advance)
            begin
                depth_reg <= merged.circuit_depth;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= gate_item;
        end
        if (advance)
        begin
            out_item_reg <= merged;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

endmodule

// File: rtl/core/agls_checker.sv
// port-level checks for the asap gate layer scheduler, bound to the top level
module agls_checker import agls_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      gate_valid,
    input logic      gate_stall,
    input agls_in_t  gate_item,
    input logic      result_valid,
    input logic      result_stall,
    input agls_out_t result_item
);

    // a gate always lies inside the depth it reports; a clear reports all zero
    a_layer_in_depth: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (result_item.circuit_depth > {1'b0, result_item.layer_index})
            || ((result_item.circuit_depth == '0) && (result_item.layer_index == '0)
                && !result_item.layer_saturated))
        else $error("layer outside reported depth");

    // clamping only ever lands on the top layer
    a_sat_top: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.layer_saturated)
            |-> (result_item.layer_index == LAYER_TOP))
        else $error("saturated item below top layer");

    // with the result side free the input is never held
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_stall |-> !gate_stall)
        else $error("input stalled with free output");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result_item)))
        else $error("stalled item changed");

endmodule

bind asap_gate_layer_scheduler agls_checker u_agls_checker (.*);
